@@ rtl/generational_slot_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

@@ rtl/gsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot allocator package
// Field widths, operation and status codes, and memory entry layouts.
// ----------------------------------------------------------------------------
package gsa_pkg;

	localparam int MAX_SLOTS_DEF = 4096;
	localparam int HARD_BYTES    = 64 * 1024 * 1024;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 12;
	localparam int GEN_W   = 32;
	localparam int BYTE_W  = 27;
	localparam int CNT_W   = 13;
	localparam int STAT_W  = 2;
	localparam int CFG_I_W = 1;

	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_HDL = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NO_ROOM = 2'd2;

	localparam logic [CFG_I_W-1:0] CFG_INSTANCE_LIMIT = 1'd0;
	localparam logic [CFG_I_W-1:0] CFG_BYTE_BUDGET    = 1'd1;

	// Per-slot record: alive flag, current generation, byte cost.
	typedef struct packed {
		logic              alive;
		logic [GEN_W-1:0]  gen;
		logic [BYTE_W-1:0] cost;
	} slot_entry_t;

	// Free stack record: index and the generation the slot holds while dead.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} stack_entry_t;

endpackage

@@ rtl/gsa_req_if.sv @@
// ----------------------------------------------------------------------------
// Slot allocator request channel
// Valid/ready channel carrying one allocator operation.
// ----------------------------------------------------------------------------
interface gsa_req_if;
	import gsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [IDX_W-1:0]  handle_index;
	logic [GEN_W-1:0]  handle_generation;
	logic [BYTE_W-1:0] request_bytes;

	modport source (output valid, opcode, handle_index, handle_generation, request_bytes,
		input ready);
	modport sink (input valid, opcode, handle_index, handle_generation, request_bytes,
		output ready);
endinterface

@@ rtl/gsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Slot allocator response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
	import gsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] result_status;
	logic [IDX_W-1:0]  out_index;
	logic [GEN_W-1:0]  out_generation;
	logic [CNT_W-1:0]  live_count;
	logic [BYTE_W-1:0] bytes_in_use;

	modport source (output valid, result_status, out_index, out_generation, live_count,
		bytes_in_use, input ready);
	modport sink (input valid, result_status, out_index, out_generation, live_count,
		bytes_in_use, output ready);
endinterface

@@ rtl/gsa_ram.sv @@
// ----------------------------------------------------------------------------
// Slot allocator RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/generational_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Generational slot allocator core
// Hands out generation-tagged slot handles under an instance limit and a
// byte budget; slot records and the free stack live in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  req     | in  | valid / ready  | opcode, handle_index, handle_generation, request_bytes
//  rsp     | out | valid / ready  | result_status, out_index, out_generation, live_count,
//          |     |                |   bytes_in_use
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
//  For each operation the transfer issues the slot and free-stack RAM reads, and the
//  execute state then checks the handle and budget and writes back.
//  No clearing pass after reset: high_water marks the slots ever handed out, and
//  slots at or above it count as dead; a fresh slot starts from generation zero.
//  A result not yet taken holds the execute cycle of the following operation.
// ----------------------------------------------------------------------------
`include "generational_slot_allocator_core_defines.svh"

module generational_slot_allocator_core #(
	parameter int MAX_SLOTS = gsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	gsa_req_if.sink                      req,
	gsa_rsp_if.source                    rsp,
	input  logic                         cfg_we,
	input  logic [gsa_pkg::CFG_I_W-1:0]  cfg_index,
	input  logic [gsa_pkg::BYTE_W-1:0]   cfg_data
);
	import gsa_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_W  = $bits(slot_entry_t);
	localparam int STACK_W = $bits(stack_entry_t);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	logic [CNT_W-1:0]  instance_limit_q;
	logic [BYTE_W-1:0] byte_budget_q;

	logic [CW-1:0]     free_depth_q;
	logic [CW-1:0]     high_water_q;
	logic [CW-1:0]     live_q;
	logic [BYTE_W-1:0] bytes_q;

	logic [OP_W-1:0]   op_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [GEN_W-1:0]  gen_s1;
	logic [BYTE_W-1:0] reqb_s1;
	logic [BYTE_W:0]   sum_s1;

	logic              rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [GEN_W-1:0]  ogen_q;

	logic accept;
	logic out_busy;
	logic advance;

	logic [CW-1:0] stk_top;

	slot_entry_t  slot_rd;
	slot_entry_t  slot_wd;
	stack_entry_t stk_rd;
	stack_entry_t stk_wd;
	logic [SLOT_W-1:0]  slot_rdata;
	logic [STACK_W-1:0] stk_rdata;
	logic               slot_we;
	logic [AW-1:0]      slot_waddr;
	logic               stk_we;

	logic [BYTE_W-1:0] budget;
	logic [CNT_W-1:0]  limit;
	logic              fresh;
	logic              hw_full;
	logic              handle_ok;
	logic [AW-1:0]     new_slot;
	logic [GEN_W-1:0]  bumped_gen;
	logic [GEN_W-1:0]  create_gen;
	logic [BYTE_W:0]   rest_sum;

	logic [STAT_W-1:0] status_d;
	logic [IDX_W-1:0]  oidx_d;
	logic [GEN_W-1:0]  ogen_d;
	logic [CW-1:0]     free_depth_d;
	logic [CW-1:0]     high_water_d;
	logic [CW-1:0]     live_d;
	logic [BYTE_W-1:0] bytes_d;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_busy = rsp_valid_q && !rsp.ready;
	assign advance  = (state_q == ST_EXEC) && !out_busy;
	assign stk_top  = free_depth_q - CW'(1);

	gsa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wd),
		.re    (accept),
		.raddr (req.handle_index[AW-1:0]),
		.rdata (slot_rdata)
	);

	gsa_ram #(.WIDTH(STACK_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (free_depth_q[AW-1:0]),
		.wdata (stk_wd),
		.re    (accept),
		.raddr (stk_top[AW-1:0]),
		.rdata (stk_rdata)
	);

	assign slot_rd = slot_rdata;
	assign stk_rd  = stk_rdata;

	assign budget  = (byte_budget_q < BYTE_W'(HARD_BYTES)) ? byte_budget_q : BYTE_W'(HARD_BYTES);
	assign limit   = (instance_limit_q < CNT_W'(MAX_SLOTS)) ? instance_limit_q
		: CNT_W'(MAX_SLOTS);
	assign fresh   = (free_depth_q == '0);
	assign hw_full = (high_water_q >= CW'(MAX_SLOTS));
	assign handle_ok = (CNT_W'(idx_s1) < CNT_W'(high_water_q)) && slot_rd.alive
		&& (slot_rd.gen == gen_s1);
	assign new_slot   = fresh ? high_water_q[AW-1:0] : stk_rd.idx[AW-1:0];
	assign create_gen = (fresh ? '0 : stk_rd.gen) + GEN_W'(1);
	assign bumped_gen = slot_rd.gen + GEN_W'(1);
	assign rest_sum   = sum_s1 - {1'b0, slot_rd.cost};

	always_comb begin
		status_d     = STATUS_OK;
		oidx_d       = '0;
		ogen_d       = '0;
		free_depth_d = free_depth_q;
		high_water_d = high_water_q;
		live_d       = live_q;
		bytes_d      = bytes_q;
		slot_we      = 1'b0;
		slot_waddr   = idx_s1[AW-1:0];
		slot_wd      = slot_rd;
		stk_we       = 1'b0;
		stk_wd.idx   = idx_s1;
		stk_wd.gen   = bumped_gen;
		case (op_s1)
			OP_CREATE: begin
				if (sum_s1 > {1'b0, budget} || CNT_W'(live_q) >= limit || (fresh && hw_full)) begin
					status_d = STATUS_NO_ROOM;
				end else begin
					if (fresh) begin
						high_water_d = high_water_q + CW'(1);
					end else begin
						free_depth_d = stk_top;
					end
					slot_we      = 1'b1;
					slot_waddr   = new_slot;
					slot_wd.alive = 1'b1;
					slot_wd.gen  = create_gen;
					slot_wd.cost = reqb_s1;
					live_d       = live_q + CW'(1);
					bytes_d      = sum_s1[BYTE_W-1:0];
					oidx_d       = IDX_W'(new_slot);
					ogen_d       = create_gen;
				end
			end
			OP_REPLACE: begin
				if (!handle_ok) begin
					status_d = STATUS_BAD_HDL;
				end else if (bytes_q < slot_rd.cost || rest_sum > {1'b0, budget}) begin
					status_d = STATUS_NO_ROOM;
				end else begin
					slot_we      = 1'b1;
					slot_wd.gen  = bumped_gen;
					slot_wd.cost = reqb_s1;
					bytes_d      = rest_sum[BYTE_W-1:0];
					oidx_d       = idx_s1;
					ogen_d       = bumped_gen;
				end
			end
			OP_REMOVE: begin
				if (!handle_ok) begin
					status_d = STATUS_BAD_HDL;
				end else begin
					slot_we       = 1'b1;
					slot_wd.alive = 1'b0;
					slot_wd.gen   = bumped_gen;
					bytes_d       = (bytes_q >= slot_rd.cost) ? bytes_q - slot_rd.cost : '0;
					if (live_q != '0) begin
						live_d = live_q - CW'(1);
					end
					// push the index with the generation it keeps while dead
					if (free_depth_q < CW'(MAX_SLOTS)) begin
						stk_we       = 1'b1;
						free_depth_d = free_depth_q + CW'(1);
					end
				end
			end
			OP_QUERY: begin
				status_d = handle_ok ? STATUS_OK : STATUS_BAD_HDL;
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
		if (!advance) begin
			slot_we = 1'b0;
			stk_we  = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instance_limit_q <= CNT_W'(4096);
			byte_budget_q    <= BYTE_W'(HARD_BYTES);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INSTANCE_LIMIT: instance_limit_q <= cfg_data[CNT_W-1:0];
				CFG_BYTE_BUDGET:    byte_budget_q    <= cfg_data;
				default:            byte_budget_q    <= byte_budget_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_depth_q <= '0;
			high_water_q <= '0;
			live_q       <= '0;
			bytes_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_EXEC;
			end else if (advance) begin
				state_q <= ST_IDLE;
			end
			if (advance) begin
				free_depth_q <= free_depth_d;
				high_water_q <= high_water_d;
				live_q       <= live_d;
				bytes_q      <= bytes_d;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// operand capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.opcode;
			idx_s1  <= req.handle_index;
			gen_s1  <= req.handle_generation;
			reqb_s1 <= req.request_bytes;
			sum_s1  <= {1'b0, bytes_q} + {1'b0, req.request_bytes};
		end
		if (advance) begin
			status_q <= status_d;
			oidx_q   <= oidx_d;
			ogen_q   <= ogen_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_status  = status_q;
	assign rsp.out_index      = oidx_q;
	assign rsp.out_generation = ogen_q;
	assign rsp.live_count     = CNT_W'(live_q);
	assign rsp.bytes_in_use   = bytes_q;

	`GSA_ASSERT_NOW(a_slot_accounting, 1'b1, (live_q + free_depth_q) == high_water_q)
	`GSA_ASSERT_NOW(a_high_water_bound, 1'b1, high_water_q <= CW'(MAX_SLOTS))
	`GSA_ASSERT_NOW(a_bytes_bound, 1'b1, bytes_q <= BYTE_W'(HARD_BYTES))
	`GSA_ASSERT_NEXT(a_exec_delivers, advance, rsp_valid_q && state_q == ST_IDLE)

endmodule
